>>> design/srdp_pkg.sv
// Package for the set reuse distance profiler: sizes, modes, states, types.
// No dependencies.
package srdp_pkg;

	localparam int Cores      = 4;
	localparam int MaxSets    = 64;
	localparam int StackDepth = 64;
	localparam int CoreW      = $clog2(Cores);
	localparam int SetW       = $clog2(MaxSets);
	localparam int PosW       = $clog2(StackDepth);
	localparam int FillW      = PosW + 1;
	localparam int StackW     = CoreW + SetW;
	localparam int MemAw      = StackW + PosW;
	localparam int CntW       = 48;
	localparam logic [CntW-1:0] CntMax = '1;

	typedef enum logic [1:0] {
		MODE_DEMAND   = 2'd0,
		MODE_PREFETCH = 2'd1,
		MODE_CLEAR    = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CLS_SHORT = 2'd0,
		CLS_MID   = 2'd1,
		CLS_LONG  = 2'd2,
		CLS_NONE  = 2'd3
	} cls_t;

	localparam logic [1:0] REG_NUM_SET     = 2'd0;
	localparam logic [1:0] REG_SHORT_LIMIT = 2'd1;
	localparam logic [1:0] REG_MID_LIMIT   = 2'd2;
	localparam logic [1:0] REG_LINE_SHIFT  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SHIFT, ST_MOD, ST_FILL, ST_FRD, ST_RD, ST_CMP,
		ST_MVRD, ST_MVWR, ST_TOP, ST_CLS, ST_OUT
	} state_t;

	typedef struct packed {
		logic        ignored;
		logic        is_cold;
		logic [5:0]  distance;
		logic [1:0]  distance_class;
		logic [CntW-1:0] short_total;
		logic [CntW-1:0] mid_total;
		logic [CntW-1:0] long_total;
		logic [CntW-1:0] cold_total;
		logic [CntW-1:0] access_total;
	} result_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  cpu;
		logic [63:0] address;
	} access_t;

endpackage

>>> design/srdp_if.sv
// Valid/ready channel interface carrying one payload type.
// No dependencies; the payload type is a parameter.
interface srdp_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/srdp_sat_counter.sv
// Saturating 48-bit event counter with synchronous clear.
// Depends on srdp_pkg.
module srdp_sat_counter (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic inc,
	output logic [srdp_pkg::CntW-1:0] count
);
	import srdp_pkg::*;
	logic [CntW-1:0] count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (clr) count_q <= '0;
		else if (inc && count_q != CntMax) count_q <= count_q + 1'b1;
	end
	assign count = count_q;
endmodule

>>> design/set_reuse_distance_profiler_top.sv
// Top level of the set reuse distance profiler; one transaction at a time.
// Prefetch, clear and unused modes go from idle straight to the output state; a demand
// access runs the line shift, 64 modulo steps and the fill read, then, on a non-empty stack,
// the entry-by-entry search and the moves down, and last the top write and classification.
// Ready only when idle and drained, so the next transaction waits for the last result.
// Reset (asynchronous, active low) empties all stacks via valid bits and zeroes counters.
module set_reuse_distance_profiler_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	srdp_if.sink   in_ch,
	srdp_if.source out_ch
);
	import srdp_pkg::*;

	logic [6:0] num_set_q, short_limit_q, mid_limit_q;
	logic [3:0] line_shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_set_q     <= 7'd64;
			short_limit_q <= 7'd12;
			mid_limit_q   <= 7'd32;
			line_shift_q  <= 4'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_SET:     num_set_q     <= cfg_data;
				REG_SHORT_LIMIT: short_limit_q <= cfg_data;
				REG_MID_LIMIT:   mid_limit_q   <= cfg_data;
				REG_LINE_SHIFT:  line_shift_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic [CoreW-1:0] cpu_q;
	logic [63:0] line_q;
	logic [63:0] rem_q;
	logic [6:0]  sets_q;
	logic [5:0]  mstep_q;
	logic [StackW-1:0] sidx_q;
	logic [FillW-1:0]  fill_q;
	logic [PosW-1:0]   pos_q;
	logic [PosW-1:0]   hit_q;
	logic        found_q;
	logic        out_valid_q;
	logic [CntW-1:0] totals [5];
	logic        ign_q, cold_q;
	logic [5:0]  dist_q;
	logic [1:0]  cls_q;
	logic        inc_s, inc_m, inc_l, inc_c, inc_a, clr_cnt;

	// Fill levels sit in a small memory. A valid bit per stack marks a level written
	// since the last reset or clear, so an unmarked stack reads as empty.
	logic [FillW-1:0] fill_mem [Cores*MaxSets];
	logic [Cores*MaxSets-1:0] fill_vld_q;
	logic [FillW-1:0]  fill_rd_q;
	logic [FillW-1:0]  fill_cur;
	logic [StackW-1:0] set_sidx, fill_raddr;
	logic              fill_we;

	// A set count of 64 leaves the low six bits as the set.
	assign set_sidx   = {cpu_q, (sets_q[6] ? line_q[SetW-1:0] : rem_q[SetW-1:0])};
	assign fill_raddr = (state_q == ST_FILL) ? set_sidx : sidx_q;
	assign fill_cur   = fill_vld_q[sidx_q] ? fill_rd_q : '0;
	assign fill_we    = (state_q == ST_TOP) && !found_q && fill_q != FillW'(StackDepth);

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[sidx_q] <= fill_q + 1'b1;
		fill_rd_q <= fill_mem[fill_raddr];
	end

	logic [63:0] stack_mem [Cores*MaxSets*StackDepth];
	logic [63:0] rd_q;
	logic        mem_we;
	logic [MemAw-1:0] mem_waddr, mem_raddr;
	logic [63:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
		rd_q <= stack_mem[mem_raddr];
	end

	logic accept;
	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;

	// Subtract/compare unit for the modulo loop, one restoring step a cycle.
	logic [69:0] sub_b;
	logic        sub_ge;
	assign sub_b  = {64'd0, sets_q[5:0]} << mstep_q;
	assign sub_ge = (sets_q[6] == 1'b0) ? ({6'd0, rem_q} >= sub_b) : 1'b0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = (in_ch.data.mode == MODE_DEMAND) ? ST_SHIFT : ST_OUT;
			ST_SHIFT: state_d = ST_MOD;
			ST_MOD:   if (mstep_q == 6'd0) state_d = ST_FILL;
			ST_FILL:  state_d = ST_FRD;
			ST_FRD:   state_d = (fill_cur == '0) ? ST_TOP : ST_RD;
			ST_RD:    state_d = ST_CMP;
			ST_CMP: begin
				if (rd_q == line_q) state_d = ST_MVRD;
				else if ({1'b0, pos_q} + 1'b1 == fill_q) state_d = ST_MVRD;
				else state_d = ST_RD;
			end
			ST_MVRD:  state_d = ({1'b0, pos_q} + 1'b1 >= fill_q) ? ST_TOP : ST_MVWR;
			ST_MVWR:  state_d = ST_MVRD;
			ST_TOP:   state_d = ST_CLS;
			ST_CLS:   state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory port control: reads fetch entry pos, moves copy pos+1 down to pos, the top write stores the line.
	logic [FillW-1:0] top_pos;
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {sidx_q, pos_q};
		mem_wdata = rd_q;
		mem_raddr = {sidx_q, pos_q};
		top_pos   = (found_q || fill_q == FillW'(StackDepth)) ? fill_q - 1'b1 : fill_q;
		unique case (state_q)
			ST_MVRD: mem_raddr = {sidx_q, PosW'(pos_q + 1'b1)};
			ST_MVWR: mem_we = 1'b1;
			ST_TOP: begin
				mem_we    = 1'b1;
				mem_waddr = {sidx_q, top_pos[PosW-1:0]};
				mem_wdata = line_q;
			end
			default: ;
		endcase
	end

	logic [PosW-1:0] d_val;
	assign d_val = PosW'(fill_q - 1'b1 - {1'b0, hit_q});

	always_comb begin
		inc_s = 1'b0; inc_m = 1'b0; inc_l = 1'b0; inc_c = 1'b0; inc_a = 1'b0;
		clr_cnt = accept && in_ch.data.mode == MODE_CLEAR;
		if (state_q == ST_CLS) begin
			inc_a = 1'b1;
			if (!found_q) inc_c = 1'b1;
			else if ({1'b0, d_val} < short_limit_q) inc_s = 1'b1;
			else if ({1'b0, d_val} < mid_limit_q) inc_m = 1'b1;
			else inc_l = 1'b1;
		end
	end

	srdp_sat_counter u_cnt_s (.clk, .arst_n, .clr(clr_cnt), .inc(inc_s), .count(totals[0]));
	srdp_sat_counter u_cnt_m (.clk, .arst_n, .clr(clr_cnt), .inc(inc_m), .count(totals[1]));
	srdp_sat_counter u_cnt_l (.clk, .arst_n, .clr(clr_cnt), .inc(inc_l), .count(totals[2]));
	srdp_sat_counter u_cnt_c (.clk, .arst_n, .clr(clr_cnt), .inc(inc_c), .count(totals[3]));
	srdp_sat_counter u_cnt_a (.clk, .arst_n, .clr(clr_cnt), .inc(inc_a), .count(totals[4]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			fill_vld_q  <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == ST_OUT) out_valid_q <= 1'b1;
			if (clr_cnt) fill_vld_q <= '0;
			else if (fill_we) fill_vld_q[sidx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) begin
				cpu_q   <= CoreW'(in_ch.data.cpu);
				line_q  <= in_ch.data.address;
				ign_q   <= 1'b1;
				cold_q  <= 1'b0;
				dist_q  <= '0;
				cls_q   <= CLS_NONE;
				sets_q  <= (num_set_q == 7'd0) ? 7'd1 :
					(num_set_q > 7'(MaxSets)) ? 7'(MaxSets) : num_set_q;
			end
			ST_SHIFT: begin
				line_q  <= line_q >> line_shift_q;
				rem_q   <= line_q >> line_shift_q;
				mstep_q <= 6'd63;
			end
			ST_MOD: begin
				if (sub_ge) rem_q <= rem_q - sub_b[63:0];
				if (mstep_q != 6'd0) mstep_q <= mstep_q - 1'b1;
			end
			ST_FILL: begin
				sidx_q  <= set_sidx;
				pos_q   <= '0;
				found_q <= 1'b0;
			end
			ST_FRD: fill_q <= fill_cur;
			ST_CMP: begin
				if (rd_q == line_q) begin
					found_q <= 1'b1;
					hit_q   <= pos_q;
				end else if ({1'b0, pos_q} + 1'b1 != fill_q) begin
					pos_q <= pos_q + 1'b1;
				end else begin
					// Cold miss: shift the whole stack down only if it is full.
					pos_q <= (fill_q == FillW'(StackDepth)) ? '0 : PosW'(fill_q - 1'b1);
				end
			end
			ST_MVWR: pos_q <= pos_q + 1'b1;
			ST_CLS: begin
				ign_q  <= 1'b0;
				cold_q <= !found_q;
				dist_q <= found_q ? 6'(d_val) : 6'd0;
				if (!found_q) cls_q <= CLS_NONE;
				else if ({1'b0, d_val} < short_limit_q) cls_q <= CLS_SHORT;
				else if ({1'b0, d_val} < mid_limit_q) cls_q <= CLS_MID;
				else cls_q <= CLS_LONG;
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;
	always_comb begin
		out_ch.data.ignored        = ign_q;
		out_ch.data.is_cold        = cold_q;
		out_ch.data.distance       = dist_q;
		out_ch.data.distance_class = cls_q;
		out_ch.data.short_total    = totals[0];
		out_ch.data.mid_total      = totals[1];
		out_ch.data.long_total     = totals[2];
		out_ch.data.cold_total     = totals[3];
		out_ch.data.access_total   = totals[4];
	end
endmodule
